// File: sv/pfr_pkg.sv
// Package for the position frame receiver: frame phases, status codes and result type.
package pfr_pkg;

    // Frame phase counter: idle, six word bytes, then the slide-flag byte
    localparam logic [2:0] PHASE_IDLE = 3'd0;
    localparam logic [2:0] PHASE_ANGLE_LAST = 3'd2;
    localparam logic [2:0] PHASE_X_LAST = 3'd4;
    localparam logic [2:0] PHASE_FLAG = 3'd7;

    // Angle limits for the status field
    localparam logic signed [15:0] ANGLE_MAX = 16'sd360;
    localparam logic signed [15:0] ANGLE_PENDING = 16'sd361;

    // Status codes
    typedef enum logic [1:0] {
        STATUS_OTHER   = 2'd0,
        STATUS_VALID   = 2'd1,
        STATUS_PENDING = 2'd2
    } pfr_status_t;

    // One completed frame
    typedef struct packed {
        logic signed [15:0] angle_value;
        logic signed [15:0] x_position;
        logic signed [15:0] y_position;
        logic [7:0]         slide_marker;
        pfr_status_t        position_status;
    } pfr_result_t;

endpackage

// File: sv/pfr_in_stage.sv
// Input register for received bytes, with valid/ready handshake.
module pfr_in_stage
    import pfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       byte_valid,
    output logic [7:0] byte_data,
    input  logic       byte_taken
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    // Slot is free when empty or drained this cycle
    assign in_ready   = !valid_reg || byte_taken;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= rx_byte;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

// File: sv/pfr_frame_parser.sv
// Frame parser: phase counter, word accumulators and result assembly.
module pfr_frame_parser
    import pfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  header_byte,
    input  logic        byte_valid,
    input  logic [7:0]  byte_data,
    output logic        byte_taken,
    input  logic        result_free,
    output logic        result_load,
    output pfr_result_t result
);

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [15:0] angle_acc_reg;
    logic [15:0] angle_acc_next;
    logic [15:0] x_acc_reg;
    logic [15:0] x_acc_next;
    logic [15:0] y_acc_reg;
    logic [15:0] y_acc_next;
    logic        at_flag;

    // Odd phase: high byte into place; even phase: OR in low byte
    function automatic logic [15:0] merge_byte(input logic [15:0] w, input logic [7:0] b,
                                               input logic odd);
        logic [15:0] ored;
        ored = w | {8'h00, b};
        return odd ? {ored[7:0], 8'h00} : ored;
    endfunction

    assign at_flag     = (phase_reg == PHASE_FLAG);
    // A flag byte needs room in the output register
    assign byte_taken  = byte_valid && (!at_flag || result_free);
    assign result_load = byte_valid && at_flag && result_free;

    // Next state of phase and accumulators
    always_comb
    begin
        phase_next     = phase_reg;
        angle_acc_next = angle_acc_reg;
        x_acc_next     = x_acc_reg;
        y_acc_next     = y_acc_reg;
        if (byte_taken)
        begin
            if (phase_reg == PHASE_IDLE)
            begin
                if (byte_data == header_byte)
                begin
                    angle_acc_next = '0;
                    x_acc_next     = '0;
                    y_acc_next     = '0;
                    phase_next     = phase_reg + 3'd1;
                end
            end
            else if (at_flag)
            begin
                phase_next = PHASE_IDLE;
            end
            else
            begin
                if (phase_reg <= PHASE_ANGLE_LAST)
                begin
                    angle_acc_next = merge_byte(angle_acc_reg, byte_data, phase_reg[0]);
                end
                else if (phase_reg <= PHASE_X_LAST)
                begin
                    x_acc_next = merge_byte(x_acc_reg, byte_data, phase_reg[0]);
                end
                else
                begin
                    y_acc_next = merge_byte(y_acc_reg, byte_data, phase_reg[0]);
                end
                phase_next = phase_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PHASE_IDLE;
            angle_acc_reg <= '0;
            x_acc_reg     <= '0;
            y_acc_reg     <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            angle_acc_reg <= angle_acc_next;
            x_acc_reg     <= x_acc_next;
            y_acc_reg     <= y_acc_next;
        end
    end

    // Result fields: X and Y negated, status from signed angle
    always_comb
    begin
        result.angle_value  = $signed(angle_acc_reg);
        result.x_position   = $signed(16'(16'd0 - x_acc_reg));
        result.y_position   = $signed(16'(16'd0 - y_acc_reg));
        result.slide_marker = byte_data;
        if ($signed(angle_acc_reg) <= ANGLE_MAX)
        begin
            result.position_status = STATUS_VALID;
        end
        else if ($signed(angle_acc_reg) == ANGLE_PENDING)
        begin
            result.position_status = STATUS_PENDING;
        end
        else
        begin
            result.position_status = STATUS_OTHER;
        end
    end

    // A result is built only on the flag byte
    a_load_on_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> (phase_reg == PHASE_FLAG))
        else $error("result loaded outside flag phase");

    // A completed frame returns the parser to idle
    a_flag_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> (phase_reg == PHASE_IDLE))
        else $error("parser not idle after frame");

    // A header clears all accumulators
    a_header_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_taken && phase_reg == PHASE_IDLE && byte_data == header_byte)
        |=> (angle_acc_reg == 16'd0 && x_acc_reg == 16'd0 && y_acc_reg == 16'd0
             && phase_reg == 3'd1))
        else $error("header did not start a clean frame");

endmodule

// File: sv/pfr_out_stage.sv
// Output register holding one finished frame until it is taken.
module pfr_out_stage
    import pfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        result_load,
    input  pfr_result_t result,
    output logic        result_free,
    output logic        out_valid,
    input  logic        out_ready,
    output pfr_result_t result_q
);

    logic        valid_reg;
    logic        valid_next;
    pfr_result_t result_reg;

    assign result_free = !valid_reg || out_ready;
    assign valid_next  = result_load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture, no reset
    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign result_q  = result_reg;

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> (!valid_reg || out_ready))
        else $error("pending result overwritten");

endmodule

// File: sv/position_frame_receiver.sv
// Position frame receiver top level: input register, frame parser, output register.
// Accepts one received byte per cycle and scans for the configured header byte;
// the seven bytes after a header carry big-endian signed angle, X and Y words and
// a slide flag. Each complete eight-byte frame yields one transaction with the angle,
// negated X and Y, the flag and a status (1: angle at most 360, 2: angle 361, 0:
// otherwise). Throughput is one byte per clock through the parser between the
// input and output registers; a result is valid in the cycle after the parser
// takes its flag byte. Bytes keep flowing while a result waits, until the next
// flag byte meets a full output register. header_byte is written through
// header_we/header_wdata and must change only while no frame is in flight.
module position_frame_receiver
    import pfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               header_we,
    input  logic [7:0]         header_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] angle_value,
    output logic signed [15:0] x_position,
    output logic signed [15:0] y_position,
    output logic [7:0]         slide_marker,
    output logic [1:0]         position_status
);

    logic [7:0]  header_reg;
    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        byte_taken;
    logic        result_free;
    logic        result_load;
    pfr_result_t result;
    pfr_result_t result_q;

    // Header byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= 8'h00;
        end
        else if (header_we)
        begin
            header_reg <= header_wdata;
        end
    end

    pfr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_taken (byte_taken)
    );

    pfr_frame_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .header_byte (header_reg),
        .byte_valid  (byte_valid),
        .byte_data   (byte_data),
        .byte_taken  (byte_taken),
        .result_free (result_free),
        .result_load (result_load),
        .result      (result)
    );

    pfr_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .result_load (result_load),
        .result      (result),
        .result_free (result_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_q    (result_q)
    );

    assign angle_value     = result_q.angle_value;
    assign x_position      = result_q.x_position;
    assign y_position      = result_q.y_position;
    assign slide_marker    = result_q.slide_marker;
    assign position_status = result_q.position_status;

endmodule
